[hw/rtl/cone_hill_height_field_assert.svh]
// Assertion macros for the hill height field block.
`ifndef CONE_HILL_HEIGHT_FIELD_ASSERT_SVH
`define CONE_HILL_HEIGHT_FIELD_ASSERT_SVH
`ifndef SYNTHESIS
`define CHF_ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define CHF_ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
		else $error("assertion failed");
`else
`define CHF_ASSERT_IMPL(label, clk, rst_n, prop)
`define CHF_ASSERT_NEXT(label, clk, rst_n, cond, nxt)
`endif
`endif

[hw/rtl/chf_pkg.sv]
// ----------------------------------------------------------------------------
// chf_pkg
// Shared types and constants of the hill height field block.
// ----------------------------------------------------------------------------
package chf_pkg;
	localparam int VAL_W = 24;
	localparam int POS_W = 10;
	localparam int GRID_SIZE = 1024;      // spans the full position range
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_EVAL  = 2'd2;
	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_DUP  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] REG_VALUE_MIN     = 2'd0;
	localparam logic [1:0] REG_VALUE_MAX     = 2'd1;
	localparam logic [1:0] REG_DEFAULT_VALUE = 2'd2;
	localparam logic signed [VAL_W-1:0] VAL_MAXI = 24'sh7FFFFF;
	localparam logic signed [VAL_W-1:0] VAL_MINI = 24'sh800000;
	localparam int RAD_W = 2*POS_W + 2;   // dx^2+dy^2 fits in 21 bits, one spare
	typedef struct packed {
		logic start;
	} sq_ctl_t;
endpackage

[hw/rtl/chf_ram.sv]
// ----------------------------------------------------------------------------
// chf_ram
// Generic single port RAM with registered read.
// ----------------------------------------------------------------------------
module chf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

[hw/rtl/chf_isqrt.sv]
// ----------------------------------------------------------------------------
// chf_isqrt
// Digit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module chf_isqrt #(
	parameter int IN_W = 38,
	parameter int OUT_W = 19
) (
	input  logic clk,
	input  logic arst_n,
	input  chf_pkg::sq_ctl_t ctl_in,
	input  logic [IN_W-1:0] radicand,
	output logic busy,
	output logic [OUT_W-1:0] root
);
	localparam int RW = 2*OUT_W;
	localparam int CW = $clog2(OUT_W+1);
	logic [RW-1:0] rem_src_q;
	logic [OUT_W+1:0] rem_q;
	logic [OUT_W-1:0] root_q;
	logic [CW-1:0] cnt_q;
	logic [OUT_W+1:0] trial, shifted;
	assign shifted = {rem_q[OUT_W-1:0], rem_src_q[RW-1 -: 2]};
	assign trial = {root_q, 2'b01};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl_in.start) begin
			cnt_q <= CW'(OUT_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			rem_src_q <= RW'(radicand);
			rem_q <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rem_src_q <= {rem_src_q[RW-3:0], 2'b00};
			if (shifted >= trial) begin
				rem_q <= shifted - trial;
				root_q <= {root_q[OUT_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				root_q <= {root_q[OUT_W-2:0], 1'b0};
			end
		end
	end
	assign busy = (cnt_q != '0);
	assign root = root_q;
endmodule

[hw/rtl/cone_hill_height_field.sv]
// Load walks the store comparing each held hill's position; eval does the same
// match scan, then a sum pass with one bit-serial square root per hill.
// One item at a time: the next item is taken in the cycle after the result is registered.
// Throughput is set by the square root unit and the store read port.
// Reset clears the hill count, configuration, control and output valid;
// the hill store itself is not cleared.
// ----------------------------------------------------------------------------
// cone_hill_height_field
// Cone hill store with evaluation of grid cells as summed cone heights.
// ----------------------------------------------------------------------------
`include "cone_hill_height_field_assert.svh"
module cone_hill_height_field #(
	parameter int MAX_HILLS = 64,
	parameter int FRAC_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] command,
	input  logic [9:0] pos_x,
	input  logic [9:0] pos_y,
	input  logic signed [23:0] hill_height_in,
	output logic out_valid,
	input  logic out_stall,
	output logic [1:0] status,
	output logic signed [23:0] cell_value,
	output logic visible,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [23:0] cfg_data
);
	localparam int AW = (MAX_HILLS > 1) ? $clog2(MAX_HILLS) : 1;
	localparam int CW = $clog2(MAX_HILLS+1);
	localparam int SQ_IN = chf_pkg::RAD_W + 2*FRAC_BITS;
	localparam int SQ_OUT = (SQ_IN+1)/2;
	localparam int WORD_W = 2*chf_pkg::POS_W + chf_pkg::VAL_W;
	localparam int ACC_W = chf_pkg::VAL_W + CW + 2;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;  // issue read
	localparam logic [2:0] S_WAIT = 3'd2;  // data arrives
	localparam logic [2:0] S_CHK  = 3'd3;  // match test
	localparam logic [2:0] S_SUMR = 3'd4;  // sum pass read
	localparam logic [2:0] S_SQ   = 3'd5;  // root busy
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0] state_q;
	logic [1:0] cmd_q;
	logic [1:0] st_q;
	logic [9:0] x_q, y_q;
	logic signed [23:0] h_q;
	logic [CW-1:0] held_q, idx_q;
	logic signed [23:0] vmin_q, vmax_q, vdef_q;
	logic signed [ACC_W-1:0] acc_q;
	logic hit_q;
	logic signed [23:0] hit_h_q;
	logic sq_go_q;
	logic sum_mode_q;
	logic [SQ_IN-1:0] rad_q;
	logic signed [23:0] hh_q;

	logic ram_we;
	logic [AW-1:0] ram_addr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;
	logic [9:0] rx, ry;
	logic signed [23:0] rh;
	logic sq_busy;
	logic [SQ_OUT-1:0] sq_root;
	chf_pkg::sq_ctl_t sq_ctl;
	logic [9:0] xin, yin;
	logic out_free;

	// Fold positions onto the grid (power-of-two size, so a mask).
	assign xin = pos_x & 10'(chf_pkg::GRID_SIZE - 1);
	assign yin = pos_y & 10'(chf_pkg::GRID_SIZE - 1);
	assign {rx, ry, rh} = ram_rdata;
	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	chf_ram #(.WIDTH(WORD_W), .DEPTH(MAX_HILLS)) u_store (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	assign sq_ctl.start = sq_go_q;
	chf_isqrt #(.IN_W(SQ_IN), .OUT_W(SQ_OUT)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .ctl_in(sq_ctl), .radicand(rad_q),
		.busy(sq_busy), .root(sq_root)
	);

	assign ram_addr = idx_q[AW-1:0];
	assign ram_we = (state_q == S_CHK) && (idx_q == held_q) && (cmd_q == chf_pkg::CMD_LOAD)
		&& (held_q < CW'(MAX_HILLS));
	assign ram_wdata = {x_q, y_q, h_q};

	// Distance inputs, absolute differences.
	logic [9:0] dx, dy;
	logic [SQ_IN-1:0] sqsum;
	assign dx = (x_q >= rx) ? x_q - rx : rx - x_q;
	assign dy = (y_q >= ry) ? y_q - ry : ry - y_q;
	assign sqsum = SQ_IN'(({11'd0, dx} * {11'd0, dx} + {11'd0, dy} * {11'd0, dy}))
		<< (2*FRAC_BITS);

	// Final value path.
	logic signed [23:0] vsat, vlo, vfin;
	always_comb begin
		if (hit_q)
			vsat = hit_h_q;
		else if (acc_q > ACC_W'(chf_pkg::VAL_MAXI))
			vsat = chf_pkg::VAL_MAXI;
		else if (acc_q < ACC_W'(chf_pkg::VAL_MINI))
			vsat = chf_pkg::VAL_MINI;
		else
			vsat = acc_q[23:0];
		vlo = (vsat < vmin_q) ? vmin_q : vsat;
		vfin = (vlo > vmax_q) ? vmax_q : vlo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vmin_q <= '0;
			vmax_q <= chf_pkg::VAL_MAXI;
			vdef_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				chf_pkg::REG_VALUE_MIN: vmin_q <= cfg_data;
				chf_pkg::REG_VALUE_MAX: vmax_q <= cfg_data;
				chf_pkg::REG_DEFAULT_VALUE: vdef_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Raise the result valid when an item finishes, drop it once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (state_q == S_DONE && out_free)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	// Pulse the root start once the hill word has been read in the sum pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sq_go_q <= 1'b0;
		else
			sq_go_q <= (state_q == S_WAIT) && sum_mode_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			held_q <= '0;
			idx_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q <= command;
						x_q <= xin;
						y_q <= yin;
						h_q <= hill_height_in;
						idx_q <= '0;
						hit_q <= 1'b0;
						acc_q <= '0;
						st_q <= chf_pkg::ST_DONE;
						if (command == chf_pkg::CMD_CLEAR)
							held_q <= '0;
						state_q <= (command == chf_pkg::CMD_LOAD || command == chf_pkg::CMD_EVAL)
							? S_SCAN : S_DONE;
					end
				end
				S_SCAN: begin
					state_q <= (idx_q == held_q) ? S_CHK : S_WAIT;
				end
				S_WAIT: begin
					if (sum_mode_q) begin
						// Sum pass: hill word is here, start its root.
						rad_q <= sqsum;
						hh_q <= rh;
						state_q <= S_SQ;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (idx_q == held_q) begin
						// Scan finished with no match.
						if (cmd_q == chf_pkg::CMD_LOAD) begin
							if (held_q < CW'(MAX_HILLS))
								held_q <= held_q + 1'b1;
							else
								st_q <= chf_pkg::ST_FULL;
							state_q <= S_DONE;
						end else begin
							idx_q <= '0;
							state_q <= (held_q == '0) ? S_DONE : S_SUMR;
						end
					end else if (rx == x_q && ry == y_q) begin
						if (cmd_q == chf_pkg::CMD_LOAD)
							st_q <= chf_pkg::ST_DUP;
						hit_q <= 1'b1;
						hit_h_q <= rh;
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_SUMR: begin
					// Issue the read once the root unit is idle.
					if (sq_go_q == 1'b0 && !sq_busy && idx_q != held_q) begin
						state_q <= S_WAIT;
					end
				end
				S_SQ: begin
					if (!sq_go_q && !sq_busy) begin
						if ($signed({1'b0, sq_root}) < hh_q)
							acc_q <= acc_q + ACC_W'(hh_q) - ACC_W'($signed({1'b0, sq_root}));
						idx_q <= idx_q + 1'b1;
						state_q <= (idx_q + 1'b1 == held_q) ? S_DONE : S_SUMR;
					end
				end
				S_DONE: begin
					// Hold the item here until the result register is free.
					if (out_free) begin
						status <= st_q;
						if (cmd_q == chf_pkg::CMD_EVAL) begin
							cell_value <= vfin;
							visible <= (vsat != vdef_q);
						end else begin
							cell_value <= '0;
							visible <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Sum mode flag: set once the match scan ends for an eval.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sum_mode_q <= 1'b0;
		else if (state_q == S_IDLE)
			sum_mode_q <= 1'b0;
		else if (state_q == S_CHK && idx_q == held_q && cmd_q == chf_pkg::CMD_EVAL)
			sum_mode_q <= 1'b1;
	end

	`CHF_ASSERT_NEXT(a_count_bound, clk, arst_n, 1'b1, held_q <= CW'(MAX_HILLS))
	`CHF_ASSERT_NEXT(a_stall_busy, clk, arst_n, in_valid && !in_stall, in_stall)
	`CHF_ASSERT_IMPL(a_no_write_full, clk, arst_n, ram_we |-> held_q < CW'(MAX_HILLS))
endmodule
